// ===== hw/rtl/kprd_pkg.sv =====
// ----------------------------------------------------------------------------
// kprd_pkg: keypad press/release debouncer definitions
// Shared types, codes and reset constants of the debouncer core.
// ----------------------------------------------------------------------------
package kprd_pkg;

  // Width of the millisecond counter by default
  localparam int unsigned TimerBitsDefault = 10;

  // Threshold registers
  localparam int unsigned ThrW = 10;
  localparam logic [ThrW-1:0] PressStableReset   = 10'd30;
  localparam logic [ThrW-1:0] ReleaseStableReset = 10'd50;

  // Configuration register indexes
  localparam int unsigned CfgAddrW = 1;
  localparam logic [CfgAddrW-1:0] CfgPressStable   = 1'b0;
  localparam logic [CfgAddrW-1:0] CfgReleaseStable = 1'b1;

  // Raw scanner code window
  localparam logic [7:0] CodeMin = 8'h44;
  localparam logic [7:0] CodeMax = 8'h5F;

  localparam int unsigned KeyW = 4;

  typedef enum logic [1:0] {
    KPRD_OP_SAMPLE = 2'd0,
    KPRD_OP_TICK   = 2'd1,
    KPRD_OP_CLEAR  = 2'd2
  } kprd_op_e;

  typedef enum logic [1:0] {
    KPRD_ST_IDLE       = 2'd0,
    KPRD_ST_PRESS_DB   = 2'd1,
    KPRD_ST_PRESSED    = 2'd2,
    KPRD_ST_RELEASE_DB = 2'd3
  } kprd_state_e;

  // Decoded key from one scanner read
  typedef struct packed {
    logic            has;
    logic [KeyW-1:0] key;
  } kprd_key_t;

  // Status reported for one beat
  typedef struct packed {
    kprd_state_e     fsm_state;
    logic [KeyW-1:0] held_key;
    logic            held_key_valid;
    logic            press_event;
  } kprd_result_t;

endpackage

// ===== hw/rtl/kprd_keymap.sv =====
// ----------------------------------------------------------------------------
// kprd_keymap: scanner code decoder
// Maps a raw scanner byte to a key index 0..15, or to no key.
// ----------------------------------------------------------------------------
module kprd_keymap (
  input  logic [7:0]         key_code_i,
  input  logic               read_ok_i,
  output kprd_pkg::kprd_key_t key_o
);

  logic [1:0] row;
  logic       in_window;

  assign row       = 2'((key_code_i - kprd_pkg::CodeMin) >> 3);
  assign in_window = (key_code_i >= kprd_pkg::CodeMin) && (key_code_i <= kprd_pkg::CodeMax)
                     && key_code_i[2];

  // row from the offset in groups of eight, column from the low two bits
  assign key_o.has = read_ok_i && in_window;
  assign key_o.key = {row, key_code_i[1:0]};

endmodule

// ===== hw/rtl/kprd_fsm.sv =====
// ----------------------------------------------------------------------------
// kprd_fsm: debounce state machine
// Holds state, candidate and confirmed keys and the millisecond counter.
// ----------------------------------------------------------------------------
module kprd_fsm #(
  parameter int unsigned TimerBits = kprd_pkg::TimerBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      beat_i,
  input  kprd_pkg::kprd_op_e        op_i,
  input  kprd_pkg::kprd_key_t       key_i,
  input  logic [kprd_pkg::ThrW-1:0] press_thr_i,
  input  logic [kprd_pkg::ThrW-1:0] release_thr_i,
  output kprd_pkg::kprd_result_t    result_o
);

  localparam int unsigned CmpW = (TimerBits > kprd_pkg::ThrW) ? TimerBits : kprd_pkg::ThrW;

  kprd_pkg::kprd_state_e         state_q, state_d;
  logic [kprd_pkg::KeyW-1:0]     cand_key_q, cand_key_d;
  logic                          cand_valid_q, cand_valid_d;
  logic [kprd_pkg::KeyW-1:0]     conf_key_q, conf_key_d;
  logic                          conf_valid_q, conf_valid_d;
  logic [TimerBits-1:0]          elapsed_q, elapsed_d;
  logic                          event_d;
  logic                          same;
  logic                          press_met;
  logic                          release_met;

  assign same        = key_i.has && cand_valid_q && (key_i.key == cand_key_q);
  assign press_met   = CmpW'(elapsed_q) >= CmpW'(press_thr_i);
  assign release_met = CmpW'(elapsed_q) >= CmpW'(release_thr_i);

  always_comb begin
    state_d      = state_q;
    cand_key_d   = cand_key_q;
    cand_valid_d = cand_valid_q;
    conf_key_d   = conf_key_q;
    conf_valid_d = conf_valid_q;
    elapsed_d    = elapsed_q;
    event_d      = 1'b0;
    unique case (op_i)
      kprd_pkg::KPRD_OP_TICK: begin
        if (elapsed_q != {TimerBits{1'b1}}) begin
          elapsed_d = elapsed_q + TimerBits'(1);
        end
      end
      kprd_pkg::KPRD_OP_CLEAR: begin
        state_d      = kprd_pkg::KPRD_ST_IDLE;
        cand_valid_d = 1'b0;
        cand_key_d   = '0;
        conf_valid_d = 1'b0;
        conf_key_d   = '0;
      end
      kprd_pkg::KPRD_OP_SAMPLE: begin
        unique case (state_q)
          kprd_pkg::KPRD_ST_IDLE: begin
            if (key_i.has) begin
              state_d      = kprd_pkg::KPRD_ST_PRESS_DB;
              cand_key_d   = key_i.key;
              cand_valid_d = 1'b1;
              elapsed_d    = '0;
            end
          end
          kprd_pkg::KPRD_ST_PRESS_DB: begin
            priority if (same) begin
              if (press_met) begin
                state_d      = kprd_pkg::KPRD_ST_PRESSED;
                conf_key_d   = cand_key_q;
                conf_valid_d = 1'b1;
                event_d      = 1'b1;
              end
            end else if (!key_i.has) begin
              state_d      = kprd_pkg::KPRD_ST_IDLE;
              cand_valid_d = 1'b0;
              cand_key_d   = '0;
            end else begin
              cand_key_d   = key_i.key;
              cand_valid_d = 1'b1;
              elapsed_d    = '0;
            end
          end
          kprd_pkg::KPRD_ST_PRESSED: begin
            if (!key_i.has) begin
              state_d   = kprd_pkg::KPRD_ST_RELEASE_DB;
              elapsed_d = '0;
            end
          end
          kprd_pkg::KPRD_ST_RELEASE_DB: begin
            priority if (same) begin
              state_d = kprd_pkg::KPRD_ST_PRESSED;
            end else if (!key_i.has) begin
              if (release_met) begin
                state_d      = kprd_pkg::KPRD_ST_IDLE;
                cand_valid_d = 1'b0;
                cand_key_d   = '0;
                conf_valid_d = 1'b0;
                conf_key_d   = '0;
              end
            end else begin
              state_d      = kprd_pkg::KPRD_ST_PRESS_DB;
              cand_key_d   = key_i.key;
              cand_valid_d = 1'b1;
              conf_valid_d = 1'b0;
              conf_key_d   = '0;
              elapsed_d    = '0;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= kprd_pkg::KPRD_ST_IDLE;
      cand_key_q   <= '0;
      cand_valid_q <= 1'b0;
      conf_key_q   <= '0;
      conf_valid_q <= 1'b0;
      elapsed_q    <= '0;
    end else if (beat_i) begin
      state_q      <= state_d;
      cand_key_q   <= cand_key_d;
      cand_valid_q <= cand_valid_d;
      conf_key_q   <= conf_key_d;
      conf_valid_q <= conf_valid_d;
      elapsed_q    <= elapsed_d;
    end
  end

  // status after this beat
  assign result_o.press_event    = event_d;
  assign result_o.held_key_valid = conf_valid_d;
  assign result_o.held_key       = conf_valid_d ? conf_key_d : '0;
  assign result_o.fsm_state      = state_d;

endmodule

// ===== hw/rtl/keypad_press_release_debouncer_core.sv =====
// ----------------------------------------------------------------------------
// keypad_press_release_debouncer_core: keypad press/release debouncer
// Result path: the result of each accepted input beat is registered in the result register.
// Throughput: one beat per cycle, set by the single result register; the
// input side stalls only while that register holds a beat not yet taken.
// Reset: asynchronous, active low; state goes idle, keys invalid, counter
// zero, thresholds back to 30 ms press and 50 ms release.
// ----------------------------------------------------------------------------
module keypad_press_release_debouncer_core #(
  parameter int unsigned TimerBits = kprd_pkg::TimerBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kprd_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [kprd_pkg::ThrW-1:0]     cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [7:0]                    s_axis_tdata_i,  // [7:0] key_code
  input  logic [2:0]                    s_axis_tuser_i,  // [1:0] opcode, [2] read_ok
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [7:0]                    m_axis_tdata_o   // [0] press_event,
                                                         // [1] held_key_valid,
                                                         // [5:2] held_key,
                                                         // [7:6] fsm_state
);

  logic [kprd_pkg::ThrW-1:0] press_thr_q;
  logic [kprd_pkg::ThrW-1:0] release_thr_q;
  logic                      in_beat;
  kprd_pkg::kprd_key_t       key;
  kprd_pkg::kprd_result_t    result;
  logic                      out_valid_q;
  kprd_pkg::kprd_result_t    out_data_q;

  // Threshold registers; the user must write them only while the core is idle, the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_thr_q   <= kprd_pkg::PressStableReset;
      release_thr_q <= kprd_pkg::ReleaseStableReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        kprd_pkg::CfgPressStable:   press_thr_q   <= cfg_data_i;
        kprd_pkg::CfgReleaseStable: release_thr_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Accept a beat whenever the result register is empty or drains now.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  kprd_keymap u_keymap (
    .key_code_i (s_axis_tdata_i),
    .read_ok_i  (s_axis_tuser_i[2]),
    .key_o      (key)
  );

  // Advance the debounce state on every accepted beat.
  kprd_fsm #(
    .TimerBits (TimerBits)
  ) u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .beat_i        (in_beat),
    .op_i          (kprd_pkg::kprd_op_e'(s_axis_tuser_i[1:0])),
    .key_i         (key),
    .press_thr_i   (press_thr_q),
    .release_thr_i (release_thr_q),
    .result_o      (result)
  );

  // Result register: load on a new beat, drop when taken, hold otherwise.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_beat) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_data_q.fsm_state, out_data_q.held_key,
                            out_data_q.held_key_valid, out_data_q.press_event};

`ifndef SYNTH
  // A press event always lands in the pressed state with a held key.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[0]) |->
      (m_axis_tdata_o[1] && (m_axis_tdata_o[7:6] == kprd_pkg::KPRD_ST_PRESSED)))
    else $error("press event outside pressed state");

  // No held key reads as key zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[1]) |-> (m_axis_tdata_o[5:2] == '0))
    else $error("held key nonzero while not valid");

  // A clear beat yields an idle result with nothing held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && (s_axis_tuser_i[1:0] == kprd_pkg::KPRD_OP_CLEAR)) |=>
      (m_axis_tvalid_o && (m_axis_tdata_o[7:6] == kprd_pkg::KPRD_ST_IDLE)
       && !m_axis_tdata_o[1] && !m_axis_tdata_o[0]))
    else $error("clear did not return to idle");

  // An empty result register never stalls the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty result register");
`endif

endmodule
